// ----- hw/rtl/rotation_matrix_to_euler_angles_defines.svh -----
// Assertion macros shared by the matrix to Euler angle converter.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RMTE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The expression must never be true.
`define RMTE_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ----- hw/rtl/rmte_pkg.sv -----
// Shared constants, types and functions of the matrix to Euler angle converter.
package rmte_pkg;

    localparam int MATRIX_FRAC_BITS = 14;
    localparam int ANGLE_FRAC_BITS  = 6;
    localparam int CORDIC_STEPS     = 16;

    localparam int MAT_W    = 16;
    localparam int ANG_FRAC = 24;
    localparam int RND_SH   = ANG_FRAC - ANGLE_FRAC_BITS;

    localparam int SQ_RAD_W  = 64;
    localparam int SQ_ROOT_W = SQ_RAD_W / 2;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;

    localparam int VW        = 36;
    localparam int ZW        = 34;
    localparam int AMT_W     = $clog2(VW);
    localparam int NORM_MSB  = 29;
    localparam int CORDIC_PREP = 3;

    localparam logic signed [MAT_W-1:0] ONE    = MAT_W'(2 ** MATRIX_FRAC_BITS);
    localparam logic [31:0]             ONE_SQ = 32'(2 ** (2 * MATRIX_FRAC_BITS));
    localparam logic signed [ZW-1:0]    DEG90  = ZW'(90 * (2 ** ANG_FRAC));

    localparam int ROLL_LIM  = 180 * (2 ** ANGLE_FRAC_BITS);
    localparam int PITCH_LIM = 90 * (2 ** ANGLE_FRAC_BITS);

    typedef struct packed {
        logic [SQ_RAD_W-1:0]  rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } t_sq;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_cv;

    typedef struct packed {
        logic signed [32:0]      d;
        logic signed [MAT_W-1:0] s;
        logic signed [MAT_W:0]   yy;
        logic signed [MAT_W:0]   yx;
        logic                    lock;
        logic                    spos;
        logic                    neg;
        logic                    nz;
    } t_side;

    typedef struct packed {
        logic lock;
        logic spos;
        logic neg;
        logic nz;
    } t_flag;

    // atan(2^-idx) in degrees with 24 fraction bits.
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = ZW'(754974720);
            1:  v = ZW'(445687602);
            2:  v = ZW'(235489088);
            3:  v = ZW'(119537938);
            4:  v = ZW'(60000934);
            5:  v = ZW'(30029717);
            6:  v = ZW'(15018523);
            7:  v = ZW'(7509720);
            8:  v = ZW'(3754917);
            9:  v = ZW'(1877466);
            10: v = ZW'(938734);
            11: v = ZW'(469367);
            12: v = ZW'(234684);
            13: v = ZW'(117342);
            14: v = ZW'(58671);
            15: v = ZW'(29335);
            16: v = ZW'(14668);
            17: v = ZW'(7334);
            18: v = ZW'(3667);
            19: v = ZW'(1833);
            20: v = ZW'(917);
            21: v = ZW'(458);
            22: v = ZW'(229);
            23: v = ZW'(115);
            24: v = ZW'(57);
            25: v = ZW'(29);
            26: v = ZW'(14);
            27: v = ZW'(7);
            28: v = ZW'(4);
            29: v = ZW'(2);
            30: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] mul16(input logic signed [MAT_W-1:0] a,
                                                 input logic signed [MAT_W-1:0] b);
        logic signed [31:0] ae;
        logic signed [31:0] be;
        ae = a;
        be = b;
        return ae * be;
    endfunction

    // Rounds half up to the output resolution and saturates to +-lim.
    function automatic logic signed [15:0] to_field(input logic signed [ZW-1:0] a,
                                                    input int lim);
        logic signed [ZW:0] t;
        logic signed [ZW:0] r;
        logic signed [ZW:0] l;
        t = {a[ZW-1], a} + (ZW+1)'(2 ** (RND_SH - 1));
        r = t >>> RND_SH;
        l = (ZW+1)'(lim);
        if (r > l) begin
            r = l;
        end else if (r < -l) begin
            r = -l;
        end
        return r[15:0];
    endfunction

endpackage

// ----- hw/rtl/rmte_sqrt_cell.sv -----
// One digit step of the pipelined integer square root.
module rmte_sqrt_cell (
    input  logic          i_clk,
    input  rmte_pkg::t_sq i_sq,
    output rmte_pkg::t_sq o_sq
);
    import rmte_pkg::*;

    logic [SQ_REM_W+1:0] rem_sh;
    logic [SQ_REM_W+1:0] trial;
    logic                ge;
    t_sq                 n_sq;
    t_sq                 r_sq;

    always_comb begin
        rem_sh    = {i_sq.rem, i_sq.rad[SQ_RAD_W-1 -: 2]};
        trial     = {2'b00, i_sq.root, 2'b01};
        ge        = rem_sh >= trial;
        n_sq.rem  = ge ? SQ_REM_W'(rem_sh - trial) : SQ_REM_W'(rem_sh);
        n_sq.root = {i_sq.root[SQ_ROOT_W-2:0], ge};
        n_sq.rad  = {i_sq.rad[SQ_RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        r_sq <= n_sq;
    end

    assign o_sq = r_sq;

endmodule

// ----- hw/rtl/rmte_sqrt.sv -----
// Floor square root as a chain of digit cells, one root bit per cycle.
module rmte_sqrt (
    input  logic                           i_clk,
    input  logic [rmte_pkg::SQ_RAD_W-1:0]  i_rad,
    output logic [rmte_pkg::SQ_ROOT_W-1:0] o_root
);
    import rmte_pkg::*;

    t_sq w_sq [0:SQ_ROOT_W];

    assign w_sq[0].rad  = i_rad;
    assign w_sq[0].rem  = '0;
    assign w_sq[0].root = '0;

    for (genvar k = 0; k < SQ_ROOT_W; k++) begin : g_cell
        rmte_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_sq  (w_sq[k]),
            .o_sq  (w_sq[k+1])
        );
    end

    assign o_root = w_sq[SQ_ROOT_W].root;

endmodule

// ----- hw/rtl/rmte_cordic_cell.sv -----
// One vectoring micro-rotation of the CORDIC chain.
module rmte_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  rmte_pkg::t_cv i_cv,
    output rmte_pkg::t_cv o_cv
);
    import rmte_pkg::*;

    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    t_cv                  n_cv;
    t_cv                  r_cv;

    always_comb begin
        dx        = i_cv.y >>> IDX;
        dy        = i_cv.x >>> IDX;
        n_cv.zero = i_cv.zero;
        if (!i_cv.y[VW-1]) begin
            n_cv.x = i_cv.x + dx;
            n_cv.y = i_cv.y - dy;
            n_cv.z = i_cv.z + atan_deg(IDX);
        end else begin
            n_cv.x = i_cv.x - dx;
            n_cv.y = i_cv.y + dy;
            n_cv.z = i_cv.z - atan_deg(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cv <= n_cv;
    end

    assign o_cv = r_cv;

endmodule

// ----- hw/rtl/rmte_cordic.sv -----
// atan2 in degrees: quadrant fold, normalization, then a chain of CORDIC cells.
module rmte_cordic #(
    parameter int STEPS = rmte_pkg::CORDIC_STEPS
) (
    input  logic                           i_clk,
    input  logic signed [rmte_pkg::VW-1:0] i_y,
    input  logic signed [rmte_pkg::VW-1:0] i_x,
    output logic signed [rmte_pkg::ZW-1:0] o_z
);
    import rmte_pkg::*;

    t_cv               n1_cv;
    logic [VW-1:0]     n1_m;
    logic [VW-1:0]     ay;
    t_cv               r1_cv;
    logic [VW-1:0]     r1_m;
    logic [AMT_W-1:0]  msb;
    logic              n2_left;
    logic [AMT_W-1:0]  n2_amt;
    t_cv               r2_cv;
    logic              r2_left;
    logic [AMT_W-1:0]  r2_amt;
    t_cv               n3_cv;
    t_cv               r3_cv;
    t_cv               w_cv [0:STEPS];

    // Fold the left half plane onto the right one.
    always_comb begin
        n1_cv.zero = (i_x == '0) && (i_y == '0);
        if (i_x[VW-1]) begin
            if (!i_y[VW-1]) begin
                n1_cv.x = i_y;
                n1_cv.y = -i_x;
                n1_cv.z = DEG90;
            end else begin
                n1_cv.x = -i_y;
                n1_cv.y = i_x;
                n1_cv.z = -DEG90;
            end
        end else begin
            n1_cv.x = i_x;
            n1_cv.y = i_y;
            n1_cv.z = '0;
        end
        ay   = n1_cv.y[VW-1] ? $unsigned(-n1_cv.y) : $unsigned(n1_cv.y);
        n1_m = ($unsigned(n1_cv.x) > ay) ? $unsigned(n1_cv.x) : ay;
    end

    // Locate the leading one so the larger component lands in [2^29, 2^30).
    always_comb begin
        msb = '0;
        for (int k = 0; k < VW; k++) begin
            if (r1_m[k]) begin
                msb = AMT_W'(k);
            end
        end
        n2_left = int'(msb) < NORM_MSB;
        n2_amt  = n2_left ? AMT_W'(NORM_MSB - int'(msb)) : AMT_W'(int'(msb) - NORM_MSB);
    end

    always_comb begin
        n3_cv = r2_cv;
        if (r2_left) begin
            n3_cv.x = r2_cv.x <<< r2_amt;
            n3_cv.y = r2_cv.y <<< r2_amt;
        end else begin
            n3_cv.x = r2_cv.x >>> r2_amt;
            n3_cv.y = r2_cv.y >>> r2_amt;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_cv   <= n1_cv;
        r1_m    <= n1_m;
        r2_cv   <= r1_cv;
        r2_left <= n2_left;
        r2_amt  <= n2_amt;
        r3_cv   <= n3_cv;
    end

    assign w_cv[0] = r3_cv;

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        rmte_cordic_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk (i_clk),
            .i_cv  (w_cv[k]),
            .o_cv  (w_cv[k+1])
        );
    end

    assign o_z = w_cv[STEPS].zero ? '0 : w_cv[STEPS].z;

endmodule

// ----- hw/rtl/rotation_matrix_to_euler_angles.sv -----
// Throughput: one matrix item per cycle; busy is never raised, o_valid pulses one cycle.
// The pipe is the input and product stages, the 32 cell square root chain, the 3 stage
// CORDIC front end, the CORDIC_STEPS rotation cells and one output stage.
// Reset is synchronous and active low; it clears only the valid pipeline.
// The receiver cannot stall, so every result leaves exactly when it is ready.
`include "rotation_matrix_to_euler_angles_defines.svh"

module rotation_matrix_to_euler_angles #(
    parameter int CORDIC_STEPS = rmte_pkg::CORDIC_STEPS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rmte_pkg::MAT_W-1:0] i_r00,
    input  logic signed [rmte_pkg::MAT_W-1:0] i_r01,
    input  logic signed [rmte_pkg::MAT_W-1:0] i_r02,
    input  logic signed [rmte_pkg::MAT_W-1:0] i_r10,
    input  logic signed [rmte_pkg::MAT_W-1:0] i_r11,
    input  logic signed [rmte_pkg::MAT_W-1:0] i_r12,
    input  logic signed [rmte_pkg::MAT_W-1:0] i_r20,
    input  logic signed [rmte_pkg::MAT_W-1:0] i_r21,
    input  logic signed [rmte_pkg::MAT_W-1:0] i_r22,
    output logic                              o_valid,
    output logic signed [14:0]                o_roll_angle,
    output logic signed [13:0]                o_pitch_angle,
    output logic signed [14:0]                o_yaw_angle,
    output logic                              o_gimbal_lock
);
    import rmte_pkg::*;

    // Cycle counts of the CORDIC section and of the whole pipe.
    localparam int CD_LAT = CORDIC_PREP + CORDIC_STEPS;
    localparam int LAT    = 6 + SQ_ROOT_W + CD_LAT;

    // Pitch field value at either end of its range.
    localparam logic signed [13:0] PITCH_END = 14'(PITCH_LIM);

    // The block never stalls; r22 does not enter any of the angles.
    assign busy = 1'b0;

    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    // Stage 0: input capture.
    logic signed [MAT_W-1:0] r0_m00, r0_m01, r0_m02, r0_m10, r0_m11, r0_m12, r0_m20, r0_m21;

    // Stage 1: all 16 by 16 products, clamped sine and the yaw vector choice.
    logic signed [MAT_W-1:0] n1_s;
    logic signed [MAT_W:0]   n1_m12, n1_m02;
    t_side                   n1_sd;
    t_side                   r1_sd;
    logic signed [31:0]      r1_p00, r1_p10, r1_p11, r1_p21, r1_p01, r1_a, r1_b, r1_ss;

    // Stage 2: norms, numerator and pitch radicand.
    logic [31:0]             r2_p, r2_q, r2_prad;
    t_side                   n2_sd;
    t_side                   r2_sd;

    // Stage 3: squared norm product and squared numerator.
    logic [32:0]             n3_ad;
    logic [63:0]             r3_n2, r3_d2;
    logic [31:0]             r3_prad;
    t_side                   r3_sd;

    // Stage 4: roll radicand.
    logic [63:0]             r4_rrad;
    logic [31:0]             r4_prad;
    t_side                   n4_sd;
    t_side                   r4_sd;

    t_side                   r_sq_side [0:SQ_ROOT_W-1];
    t_flag                   r_cd_flag [0:CD_LAT-1];
    t_side                   w_sd;
    t_flag                   w_fl;

    logic [SQ_ROOT_W-1:0]    w_c;
    logic [SQ_ROOT_W-1:0]    w_sn;
    logic signed [ZW-1:0]    w_zp, w_zy, w_zr;

    logic signed [ZW-1:0]    n_pitch, n_roll;
    logic signed [15:0]      n_rf, n_pf, n_yf;

    logic                    w_pitch_end;
    logic                    w_pitch_over;

    always_comb begin
        n_vld = {r_vld[LAT-2:0], start && !busy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_m00 <= i_r00;
        r0_m01 <= i_r01;
        r0_m02 <= i_r02;
        r0_m10 <= i_r10;
        r0_m11 <= i_r11;
        r0_m12 <= i_r12;
        r0_m20 <= i_r20;
        r0_m21 <= i_r21;
    end

    // Clamp r20 to +-1.0; reaching either end means gimbal lock. In lock the yaw
    // comes from column two, negated when the pitch is positive.
    always_comb begin
        n1_sd = '0;
        if (r0_m20 >= ONE) begin
            n1_s = ONE;
        end else if (r0_m20 <= -ONE) begin
            n1_s = -ONE;
        end else begin
            n1_s = r0_m20;
        end
        n1_sd.s    = n1_s;
        n1_sd.lock = (n1_s == ONE) || (n1_s == -ONE);
        n1_sd.spos = !n1_s[MAT_W-1] && (n1_s != '0);
        n1_sd.neg  = !r0_m21[MAT_W-1] && (r0_m21 != '0);
        n1_m12     = {r0_m12[MAT_W-1], r0_m12};
        n1_m02     = {r0_m02[MAT_W-1], r0_m02};
        if (n1_sd.lock) begin
            n1_sd.yy = n1_sd.spos ? -n1_m12 : n1_m12;
            n1_sd.yx = n1_sd.spos ? -n1_m02 : n1_m02;
        end else begin
            n1_sd.yy = {r0_m10[MAT_W-1], r0_m10};
            n1_sd.yx = {r0_m00[MAT_W-1], r0_m00};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sd  <= n1_sd;
        r1_p00 <= mul16(r0_m00, r0_m00);
        r1_p10 <= mul16(r0_m10, r0_m10);
        r1_p11 <= mul16(r0_m11, r0_m11);
        r1_p21 <= mul16(r0_m21, r0_m21);
        r1_p01 <= mul16(r0_m01, r0_m01);
        r1_a   <= mul16(r0_m11, r0_m00);
        r1_b   <= mul16(r0_m01, r0_m10);
        r1_ss  <= mul16(n1_s, n1_s);
    end

    // The side data picks up the roll numerator here.
    always_comb begin
        n2_sd   = r1_sd;
        n2_sd.d = {r1_a[31], r1_a} - {r1_b[31], r1_b};
    end

    // Squares are non-negative and below 2^31, so their sums fit in 32 unsigned bits.
    always_ff @(posedge i_clk) begin
        r2_p    <= $unsigned(r1_p00) + $unsigned(r1_p10);
        r2_q    <= $unsigned(r1_p11) + $unsigned(r1_p21) + $unsigned(r1_p01);
        r2_prad <= ONE_SQ - $unsigned(r1_ss);
        r2_sd   <= n2_sd;
    end

    always_comb begin
        n3_ad = r2_sd.d[32] ? $unsigned(-r2_sd.d) : $unsigned(r2_sd.d);
    end

    always_ff @(posedge i_clk) begin
        r3_n2   <= 64'(r2_p) * 64'(r2_q);
        r3_d2   <= 64'(n3_ad[31:0]) * 64'(n3_ad[31:0]);
        r3_prad <= r2_prad;
        r3_sd   <= r2_sd;
    end

    // A zero norm product marks a roll that is forced to zero.
    always_comb begin
        n4_sd    = r3_sd;
        n4_sd.nz = r3_n2 != '0;
    end

    // The radicand cannot go negative for integer inputs; zero guards it anyway.
    always_ff @(posedge i_clk) begin
        r4_rrad <= (r3_n2 >= r3_d2) ? (r3_n2 - r3_d2) : '0;
        r4_prad <= r3_prad;
        r4_sd   <= n4_sd;
    end

    rmte_sqrt u_sqrt_roll (
        .i_clk  (i_clk),
        .i_rad  (r4_rrad),
        .o_root (w_sn)
    );

    rmte_sqrt u_sqrt_pitch (
        .i_clk  (i_clk),
        .i_rad  (SQ_RAD_W'(r4_prad)),
        .o_root (w_c)
    );

    // Side data rides along the square root chain and then the CORDIC chain.
    always_ff @(posedge i_clk) begin
        r_sq_side[0] <= r4_sd;
        for (int k = 1; k < SQ_ROOT_W; k++) begin
            r_sq_side[k] <= r_sq_side[k-1];
        end
        r_cd_flag[0] <= {w_sd.lock, w_sd.spos, w_sd.neg, w_sd.nz};
        for (int k = 1; k < CD_LAT; k++) begin
            r_cd_flag[k] <= r_cd_flag[k-1];
        end
    end

    assign w_sd = r_sq_side[SQ_ROOT_W-1];
    assign w_fl = r_cd_flag[CD_LAT-1];

    // Pitch is asin(s) taken as atan2(s, sqrt(1 - s^2)).
    rmte_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_pitch (
        .i_clk (i_clk),
        .i_y   (VW'(w_sd.s)),
        .i_x   (VW'(w_c)),
        .o_z   (w_zp)
    );

    rmte_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_yaw (
        .i_clk (i_clk),
        .i_y   (VW'(w_sd.yy)),
        .i_x   (VW'(w_sd.yx)),
        .o_z   (w_zy)
    );

    // Roll is acos(d / n) taken as atan2(sqrt(n^2 - d^2), d).
    rmte_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_roll (
        .i_clk (i_clk),
        .i_y   (VW'(w_sn)),
        .i_x   (VW'(w_sd.d)),
        .o_z   (w_zr)
    );

    // In gimbal lock the pitch is exactly +-90 and the roll is zero; a zero norm
    // also gives zero roll. Roll takes the opposite sign when r21 is positive.
    always_comb begin
        if (w_fl.lock) begin
            n_pitch = w_fl.spos ? DEG90 : -DEG90;
        end else begin
            n_pitch = w_zp;
        end
        if (w_fl.lock || !w_fl.nz) begin
            n_roll = '0;
        end else begin
            n_roll = w_fl.neg ? -w_zr : w_zr;
        end
        n_rf = to_field(n_roll, ROLL_LIM);
        n_pf = to_field(n_pitch, PITCH_LIM);
        n_yf = to_field(w_zy, ROLL_LIM);
    end

    always_ff @(posedge i_clk) begin
        o_roll_angle  <= n_rf[14:0];
        o_pitch_angle <= n_pf[13:0];
        o_yaw_angle   <= n_yf[14:0];
        o_gimbal_lock <= w_fl.lock;
    end

    assign o_valid = r_vld[LAT-1];

    assign w_pitch_end  = (o_pitch_angle == PITCH_END) || (o_pitch_angle == -PITCH_END);
    assign w_pitch_over = (o_pitch_angle > PITCH_END) || (o_pitch_angle < -PITCH_END);

    `RMTE_ASSERT_IMPL(a_lock_roll_zero, o_valid && o_gimbal_lock, o_roll_angle == '0)
    `RMTE_ASSERT_IMPL(a_lock_pitch_end, o_valid && o_gimbal_lock, w_pitch_end)
    `RMTE_ASSERT_IMPL(a_valid_has_item, o_valid, $past(start && !busy, LAT))
    `RMTE_ASSERT_NEVER(a_pitch_in_range, o_valid && w_pitch_over)

endmodule
